FILE: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the running median filter
// Control word broadcast to the cell row and the window register format.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int CSR_BITS = 7;
   localparam logic [CSR_BITS-1:0] WINDOW_RESET = 7'd3;

   // step: a word enters; purge: one stale entry leaves; clear: restart window
   typedef struct packed {
      logic step;
      logic purge;
      logic clear;
   } ctl_type;

endpackage

FILE: hw/rtl/swm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_req_if: sample channel
// valid/ready handshake carrying one sample word and the restart flag.
// ----------------------------------------------------------------------------
interface swm_req_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          start_new;

   modport source (output valid, output sample, output start_new, input ready);
   modport sink   (input valid, input sample, input start_new, output ready);
endinterface

FILE: hw/rtl/swm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_rsp_if: median channel
// valid/ready handshake carrying one median word.
// ----------------------------------------------------------------------------
interface swm_rsp_if #(
   parameter int SAMPLE_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

FILE: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds a value and its age; each update it keeps its entry, takes the
// neighbor's, or takes the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
   parameter int SAMPLE_BITS = 32,
   parameter int AW          = 6,
   parameter int KW          = 7,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swm_pkg::ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0] new_sample,
   input  logic [KW-1:0]                 k,
   input  logic [KW-1:0]                 fill_next,
   input  logic                          hit_in,
   output logic                          hit_out,
   input  logic signed [SAMPLE_BITS-1:0] left_value,
   input  logic [AW-1:0]                 left_age,
   input  logic                          left_mv_right,
   input  logic signed [SAMPLE_BITS-1:0] right_value,
   input  logic [AW-1:0]                 right_age,
   input  logic                          right_mv_left,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic [AW-1:0]                 age_nx,
   output logic                          mv_left,
   output logic                          mv_right,
   output logic                          stale,
   output logic                          valid
);
   import swm_pkg::*;

   logic                          valid_ff, valid_in;
   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [AW-1:0]                 age_ff, age_in;
   logic                          valid_eff, expire, flag, kept, gt, stay, enable;

   always_comb begin
      valid_eff = valid_ff && !(ctl.step && ctl.clear);
      stale     = valid_ff && (KW'(age_ff) >= k);
      expire    = valid_eff && ((KW'(age_ff) + KW'(1)) >= k);
      flag      = ctl.purge ? stale : expire;
      hit_out   = hit_in | flag;
      kept      = valid_eff && !(flag && !hit_in);
      gt        = ctl.step && kept && (value_ff > new_sample);
      mv_right  = kept && gt && !hit_in;
      mv_left   = kept && hit_in && !gt;
      stay      = kept && (hit_in == gt);
      age_nx    = ctl.step ? age_ff + AW'(1) : age_ff;
      value     = value_ff;
      valid     = valid_ff;
      enable    = ctl.step | ctl.purge;
      valid_in  = fill_next > KW'(INDEX);
      if (right_mv_left) begin
         value_in = right_value;
         age_in   = right_age;
      end else if (left_mv_right) begin
         value_in = left_value;
         age_in   = left_age;
      end else if (stay) begin
         value_in = value_ff;
         age_in   = age_nx;
      end else begin
         value_in = new_sample;
         age_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

endmodule

FILE: hw/rtl/sliding_window_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median: running median filter over a sliding window
// Sorted row of cells with ages; emits the entry at index K/2 once full.
// ----------------------------------------------------------------------------
// Accepts one sample word per clock, save while stale entries leave or a
// second median waits, and returns one median word per sample once the
// window holds K samples; the median is held pending, then captured into a
// registered output, so a stalled output does not stop intake until a second
// median is waiting. Every cell updates in the same cycle: an insert and an
// expiry move each entry by at most one slot. After csr_wr_data shrinks the
// window, entries too old for the new size leave one per cycle before the
// next sample is taken. start_new empties the window before its sample enters.
// ----------------------------------------------------------------------------
module sliding_window_median #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   swm_req_if.sink                      req_bus,
   swm_rsp_if.source                    rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [swm_pkg::CSR_BITS-1:0] csr_wr_data
);
   import swm_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int KW = $clog2(WINDOW_MAX + 1);
   localparam int CW = (KW > CSR_BITS) ? KW : CSR_BITS;

   logic [CSR_BITS-1:0]           window_size_ff;
   logic [KW-1:0]                 fill_ff, fill_in;
   logic                          pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_median_ff;

   logic [KW-1:0]                 k_eff;
   logic [AW-1:0]                 mid;
   logic                          stale_any, capture, emit;
   ctl_type                       ctl;

   logic signed [SAMPLE_BITS-1:0] link_value [WINDOW_MAX+2];
   logic [AW-1:0]                 link_age   [WINDOW_MAX+2];
   logic                          link_mv_l  [WINDOW_MAX+2];
   logic                          link_mv_r  [WINDOW_MAX+2];
   logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
   logic                          hit        [WINDOW_MAX+1];
   logic [WINDOW_MAX-1:0]         stale_vec;
   logic [WINDOW_MAX-1:0]         valid_vec;

   assign link_value[0]            = '0;
   assign link_age[0]              = '0;
   assign link_mv_l[0]             = 1'b0;
   assign link_mv_r[0]             = 1'b0;
   assign link_value[WINDOW_MAX+1] = '0;
   assign link_age[WINDOW_MAX+1]   = '0;
   assign link_mv_l[WINDOW_MAX+1]  = 1'b0;
   assign link_mv_r[WINDOW_MAX+1]  = 1'b0;
   assign hit[0]                   = 1'b0;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .AW          (AW),
         .KW          (KW),
         .INDEX       (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .new_sample    (req_bus.sample),
         .k             (k_eff),
         .fill_next     (fill_in),
         .hit_in        (hit[i]),
         .hit_out       (hit[i+1]),
         .left_value    (link_value[i]),
         .left_age      (link_age[i]),
         .left_mv_right (link_mv_r[i]),
         .right_value   (link_value[i+2]),
         .right_age     (link_age[i+2]),
         .right_mv_left (link_mv_l[i+2]),
         .value         (link_value[i+1]),
         .age_nx        (link_age[i+1]),
         .mv_left       (link_mv_l[i+1]),
         .mv_right      (link_mv_r[i+1]),
         .stale         (stale_vec[i]),
         .valid         (valid_vec[i])
      );
      assign cell_value[i] = link_value[i+1];
   end

   always_comb begin
      if (window_size_ff == '0) begin
         k_eff = KW'(1);
      end else if (CW'(window_size_ff) > CW'(WINDOW_MAX)) begin
         k_eff = KW'(WINDOW_MAX);
      end else begin
         k_eff = KW'(window_size_ff);
      end
      mid       = AW'(k_eff >> 1);
      stale_any = |stale_vec;
      capture   = pend_ff && (!rsp_valid_ff || rsp_bus.ready);
      req_bus.ready = !stale_any && (!pend_ff || capture);
      ctl.step  = req_bus.valid && req_bus.ready;
      ctl.purge = stale_any;
      ctl.clear = req_bus.start_new;
      if (ctl.step) begin
         fill_in = req_bus.start_new ? KW'(1)
                                     : fill_ff - KW'(hit[WINDOW_MAX]) + KW'(1);
      end else if (ctl.purge) begin
         fill_in = fill_ff - KW'(1);
      end else begin
         fill_in = fill_ff;
      end
      emit = ctl.step && (fill_in == k_eff);
      if (emit) begin
         pend_in = 1'b1;
      end else if (capture) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_RESET;
         fill_ff        <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            window_size_ff <= csr_wr_data;
         end
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         rsp_median_ff <= cell_value[mid];
      end
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.median = rsp_median_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      !stale_any |-> fill_ff <= k_eff)
      else $error("window holds more than K entries");

   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == fill_ff)
      else $error("cell valid bits disagree with fill count");

   a_emit_pend: assert property (@(posedge clock) disable iff (reset)
      emit |=> pend_ff)
      else $error("full window produced no pending median");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      ctl.step && req_bus.start_new |=> fill_ff == KW'(1))
      else $error("restart did not leave one entry");

endmodule

FILE: tb/sliding_window_median_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_tb: self-checking bench for the running median filter
// Drives sample words in random bursts against a stalling median sink. Every
// median is checked against its directed row or an in-bench sorted-window
// predictor; window size sweeps its extremes on fresh sequences and mid-stream.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;
   import swm_pkg::*;

   localparam int WINDOW_MAX  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int SETTLE      = 8;
   localparam int STALL_LIMIT = 4000;
   localparam int N_DIR       = 27;
   localparam int N_PHASES    = 9;

   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 32'sh7FFF_FFFF;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          restart;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] median;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;

   swm_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_if ();
   swm_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_if ();

   sliding_window_median #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_if),
      .rsp_bus    (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the window, kept sorted, ties oldest first
   logic signed [SAMPLE_BITS-1:0] win_vals [WINDOW_MAX];
   int                            win_ages [WINDOW_MAX];
   int                            win_fill;
   logic [CSR_BITS-1:0]           csr_window;

   logic signed [SAMPLE_BITS-1:0] median_q [$];
   logic signed [SAMPLE_BITS-1:0] want_median;

   int err_count    = 0;
   int words_sent   = 0;
   int medians_seen = 0;
   int restarts     = 0;
   int csr_writes   = 0;
   int quiet_cycles = 0;

   int stall_mode = 0;
   int stall_left = 0;
   int rx_cycle   = 0;

   stim_row_type dir_rows [N_DIR] = '{
      '{ROW_WORD, 32'sd5,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, -32'sd3,       1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd7,        1'b0, 1'b1, 32'sd5},
      '{ROW_WORD, S_MIN,         1'b1, 1'b0, 32'sd0},
      '{ROW_WORD, S_MAX,         1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd0,        1'b0, 1'b1, 32'sd0},
      '{ROW_WORD, S_MAX,         1'b0, 1'b1, S_MAX},
      '{ROW_WORD, S_MIN,         1'b0, 1'b1, 32'sd0},
      '{ROW_CSR,  32'sd1,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, -32'sd1,       1'b0, 1'b1, -32'sd1},
      '{ROW_WORD, S_MIN,         1'b0, 1'b1, S_MIN},
      '{ROW_CSR,  32'sd2,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd4,        1'b0, 1'b1, 32'sd4},
      '{ROW_WORD, 32'sd3,        1'b0, 1'b1, 32'sd4},
      '{ROW_CSR,  32'sd0,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd9,        1'b0, 1'b1, 32'sd9},
      '{ROW_CSR,  32'sd127,      1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd1,        1'b1, 1'b0, 32'sd0},
      '{ROW_CSR,  32'sd5,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd2,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd2,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd2,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, -32'sd2,       1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd6,        1'b0, 1'b0, 32'sd0},
      '{ROW_CSR,  32'sd3,        1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, 32'sd100,      1'b0, 1'b0, 32'sd0},
      '{ROW_WORD, -32'sd100,     1'b1, 1'b0, 32'sd0}
   };

   task automatic report_mismatch(input string what,
                                  input logic signed [SAMPLE_BITS-1:0] got,
                                  input logic signed [SAMPLE_BITS-1:0] want);
      err_count++;
      if (err_count <= 20)
         $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // one sample through the window; returns 1 when a median comes out
   function automatic bit slide_window(input logic signed [SAMPLE_BITS-1:0] s,
                                       input bit restart,
                                       output logic signed [SAMPLE_BITS-1:0] med);
      logic signed [SAMPLE_BITS-1:0] nv [WINDOW_MAX];
      int  na [WINDOW_MAX];
      int  k;
      int  cnt;
      int  age;
      bit  placed;
      k      = int'(csr_window);
      cnt    = 0;
      placed = 1'b0;
      med    = '0;
      if (k == 0) k = 1;
      if (k > WINDOW_MAX) k = WINDOW_MAX;
      if (restart) win_fill = 0;
      for (int i = 0; i < win_fill; i++) begin
         age = win_ages[i] + 1;
         if (age < k) begin
            if (!placed && win_vals[i] > s) begin
               if (cnt < WINDOW_MAX) begin
                  nv[cnt] = s;
                  na[cnt] = 0;
                  cnt++;
               end
               placed = 1'b1;
            end
            if (cnt < WINDOW_MAX) begin
               nv[cnt] = win_vals[i];
               na[cnt] = age;
               cnt++;
            end
         end
      end
      if (!placed && cnt < WINDOW_MAX) begin
         nv[cnt] = s;
         na[cnt] = 0;
         cnt++;
      end
      for (int i = 0; i < cnt; i++) begin
         win_vals[i] = nv[i];
         win_ages[i] = na[i];
      end
      win_fill = cnt;
      if (win_fill == k) begin
         med = win_vals[k / 2];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic send_word(input logic signed [SAMPLE_BITS-1:0] s, input bit restart,
                            input bit known, input logic signed [SAMPLE_BITS-1:0] typed);
      logic signed [SAMPLE_BITS-1:0] med;
      bit has_med;
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.sample    <= s;
      req_if.start_new <= restart;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      has_med = slide_window(s, restart, med);
      if (known) median_q = {median_q, typed};
      else if (has_med) median_q = {median_q, med};
      words_sent++;
      if (restart) restarts++;
   endtask

   task automatic drain_medians();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (median_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [CSR_BITS-1:0] v);
      drain_medians();
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_window  = v;
      csr_writes++;
   endtask

   // median sink: stall pattern switches among four modes at random
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 96);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_if.ready <= 1'b1;
         1: rsp_if.ready <= $urandom_range(0, 1) == 1;
         2: rsp_if.ready <= $urandom_range(0, 3) == 0;
         default: rsp_if.ready <= (rx_cycle % 5) != 0;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         medians_seen++;
         if (median_q.size() == 0) begin
            report_mismatch("median word with none pending", rsp_if.median, '0);
         end else begin
            want_median = median_q.pop_front();
            if (rsp_if.median !== want_median)
               report_mismatch("median", rsp_if.median, want_median);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles, %0d medians pending",
                  quiet_cycles, median_q.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int n_items;
      int pause_at;
      int burst_left;
      int gap;
      bit fresh;
      bit restart;
      logic [CSR_BITS-1:0] ksel;
      logic signed [SAMPLE_BITS-1:0] s;
      logic signed [SAMPLE_BITS-1:0] prev_s;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.start_new = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_window       = WINDOW_RESET;
      win_fill         = 0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         win_vals[i] = '0;
         win_ages[i] = 0;
      end
      burst_left = 0;
      prev_s     = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIR; r++) begin
         if (dir_rows[r].kind == ROW_CSR)
            write_window(dir_rows[r].value[CSR_BITS-1:0]);
         else
            send_word(dir_rows[r].value, dir_rows[r].restart, dir_rows[r].known,
                      dir_rows[r].median);
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: ksel = 7'd1;
            1: ksel = 7'd2;
            2: ksel = 7'd7;
            3: ksel = 7'd64;
            4: ksel = 7'd127;
            5: ksel = 7'd0;
            6: ksel = 7'($urandom_range(3, 16));
            7: ksel = 7'($urandom_range(0, 127));
            default: ksel = 7'd4;
         endcase
         write_window(ksel);
         fresh    = $urandom_range(0, 1) == 1;
         n_items  = $urandom_range(60, 84);
         pause_at = $urandom_range(10, n_items - 10);
         for (int i = 0; i < n_items; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               if (gap > 0) begin
                  @(negedge clock);
                  req_if.valid     <= 1'b0;
                  req_if.sample    <= $urandom;
                  req_if.start_new <= 1'($urandom_range(0, 1));
                  repeat (gap - 1) @(negedge clock);
               end
            end
            burst_left--;
            case ($urandom_range(0, 9))
               0, 1, 2, 3: s = $signed(32'($urandom_range(0, 12))) - 32'sd6;
               4, 5, 6:    s = $urandom;
               7: begin
                  case ($urandom_range(0, 5))
                     0: s = S_MIN;
                     1: s = S_MAX;
                     2: s = S_MIN + 32'sd1;
                     3: s = S_MAX - 32'sd1;
                     4: s = '0;
                     default: s = -32'sd1;
                  endcase
               end
               default: s = prev_s + $signed(32'($urandom_range(0, 20))) - 32'sd10;
            endcase
            prev_s  = s;
            restart = (i == 0 && fresh) || ($urandom_range(0, 59) == 0);
            if (i == pause_at) drain_medians();
            send_word(s, restart, 1'b0, '0);
         end
      end

      drain_medians();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d sample words (%0d restarts) across %0d window size writes;",
               words_sent, restarts, csr_writes);
      $display("%0d median words checked, %0d mismatches", medians_seen, err_count);
      if (err_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_req_if.sv
hw/rtl/swm_rsp_if.sv
hw/rtl/swm_cell.sv
hw/rtl/sliding_window_median.sv
tb/sliding_window_median_tb.sv
